// File: design/btrq_pkg.sv
// ----------------------------------------------------------------------------
// btrq_pkg: shared types and codes for the box table range query block
// Holds the box record type, the command and status codes, the controller
// states and the per-cell control group.
// ----------------------------------------------------------------------------
package btrq_pkg;

    localparam logic [1:0] CMD_ADD       = 2'd0;
    localparam logic [1:0] CMD_REMOVE_ID = 2'd1;
    localparam logic [1:0] CMD_REMOVE_PT = 2'd2;
    localparam logic [1:0] CMD_QUERY     = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NONE  = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
    } box_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// File: design/btrq_cell.sv
// ----------------------------------------------------------------------------
// btrq_cell: one table slot
// Holds one box. It loads a new box when selected, otherwise takes the box
// of its upper neighbor when the table shifts toward the head.
// ----------------------------------------------------------------------------
module btrq_cell (
    input  logic                aclk,
    input  btrq_pkg::cell_ctrl_t ctrl,
    input  btrq_pkg::box_t      load_data,
    input  btrq_pkg::box_t      next_data,
    output btrq_pkg::box_t      q
);

    btrq_pkg::box_t box_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            box_reg <= load_data;
        end else if (ctrl.shift) begin
            box_reg <= next_data;
        end
    end

    assign q = box_reg;

endmodule

// File: design/box_table_range_query.sv
// ----------------------------------------------------------------------------
// box_table_range_query: ordered box table with removal and range query
// A row of slot cells holds the boxes in table order; a controller walks the
// row through its head cell.
// ----------------------------------------------------------------------------
// An add gives one result transfer. Remove by handle, remove at point and
// query walk the whole occupied table: each stored box passes the head cell
// once, one box per cycle while no query result waits on a stalled result
// side, and a box that stays is written back behind the others.
// A query gives one transfer per overlapping box, or one with no match if
// none overlaps; each is held back until the next overlapping box is found,
// so the final one can carry last. New items are taken only when idle.
module box_table_range_query #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [14:0]        s_size_w,
    input  logic [14:0]        s_size_h,
    input  logic [15:0]        s_handle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_match,
    output logic [15:0]        m_hit_handle,
    output logic signed [15:0] m_hit_x,
    output logic signed [15:0] m_hit_y,
    output logic [14:0]        m_hit_w,
    output logic [14:0]        m_hit_h,
    output logic [15:0]        m_extent_x,
    output logic [15:0]        m_extent_y,
    output logic               m_last
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    btrq_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]   occ_reg, steps_reg;
    logic [1:0]         cmd_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [14:0]        w_reg, h_reg;
    logic [15:0]        handle_reg;
    logic               any_reg, found_reg, pend_valid_reg;
    btrq_pkg::box_t     pend_reg, removed_reg;
    logic signed [16:0] max_r_reg, max_b_reg, cand_r_reg, cand_b_reg;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic               m_match_reg, m_last_reg;
    btrq_pkg::box_t     m_box_reg;
    logic [15:0]        m_ext_x_reg, m_ext_y_reg;

    btrq_pkg::box_t     cell_q [MAX_ENTRIES];
    btrq_pkg::box_t     head, in_box, load_data;
    btrq_pkg::cell_ctrl_t cell_ctrl [MAX_ENTRIES];
    logic [IDX_W-1:0]   wr_idx;

    logic               out_free, accept, add_ok, add_full;
    logic               step_go, push, need_emit, keep, scan_done;
    logic               out_load, out_match, out_last;
    logic [1:0]         out_status;
    btrq_pkg::box_t     out_box;
    logic signed [16:0] out_ext_r, out_ext_b;

    logic signed [16:0] h_left, h_top, h_right, h_bottom;
    logic signed [16:0] px, py, qr, qb, in_right, in_bottom, add_r, add_b;
    logic               id_hit, contains, overlaps;

    assign out_free = !m_valid_reg || m_ready;
    assign head     = cell_q[0];

    assign in_box.id     = s_handle;
    assign in_box.left   = s_pos_x;
    assign in_box.top    = s_pos_y;
    assign in_box.width  = s_size_w;
    assign in_box.height = s_size_h;

    // Head cell geometry against the latched command operands.
    assign h_left   = {head.left[15], head.left};
    assign h_top    = {head.top[15], head.top};
    assign h_right  = h_left + $signed({2'b00, head.width});
    assign h_bottom = h_top + $signed({2'b00, head.height});
    assign px       = {x_reg[15], x_reg};
    assign py       = {y_reg[15], y_reg};
    assign qr       = px + $signed({2'b00, w_reg});
    assign qb       = py + $signed({2'b00, h_reg});

    assign id_hit   = (head.id == handle_reg);
    assign contains = (px >= h_left) && (px < h_right) && (py >= h_top) && (py < h_bottom);
    assign overlaps = (h_left <= qr) && (h_top <= qb) && (h_right >= px) && (h_bottom >= py);

    assign in_right  = $signed({s_pos_x[15], s_pos_x}) + $signed({2'b00, s_size_w});
    assign in_bottom = $signed({s_pos_y[15], s_pos_y}) + $signed({2'b00, s_size_h});
    assign add_r     = (in_right > max_r_reg) ? in_right : max_r_reg;
    assign add_b     = (in_bottom > max_b_reg) ? in_bottom : max_b_reg;

    assign accept   = s_valid && s_ready;
    assign add_full = (occ_reg == CNT_W'(MAX_ENTRIES));
    assign add_ok   = accept && (s_cmd == btrq_pkg::CMD_ADD) && !add_full;
    assign scan_done = (steps_reg == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            btrq_pkg::ST_IDLE: begin
                if (accept && (s_cmd != btrq_pkg::CMD_ADD)) begin
                    state_next = btrq_pkg::ST_SCAN;
                end
            end
            btrq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = btrq_pkg::ST_FINISH;
                end
            end
            btrq_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = btrq_pkg::ST_IDLE;
                end
            end
            default: state_next = btrq_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs: scan step control and the result to load.
    always_comb begin
        s_ready    = 1'b0;
        keep       = 1'b1;
        need_emit  = 1'b0;
        step_go    = 1'b0;
        out_load   = 1'b0;
        out_status = btrq_pkg::STATUS_OK;
        out_match  = 1'b0;
        out_last   = 1'b1;
        out_box    = '0;
        out_ext_r  = max_r_reg;
        out_ext_b  = max_b_reg;
        unique case (cmd_reg)
            btrq_pkg::CMD_REMOVE_ID: keep = !id_hit;
            btrq_pkg::CMD_REMOVE_PT: keep = !(contains && !found_reg);
            default:                 keep = 1'b1;
        endcase
        unique case (state_reg)
            btrq_pkg::ST_IDLE: begin
                s_ready = out_free;
                if (accept && (s_cmd == btrq_pkg::CMD_ADD)) begin
                    out_load = 1'b1;
                    if (add_full) begin
                        out_status = btrq_pkg::STATUS_FULL;
                    end else begin
                        out_ext_r = add_r;
                        out_ext_b = add_b;
                    end
                end
            end
            btrq_pkg::ST_SCAN: begin
                need_emit = (cmd_reg == btrq_pkg::CMD_QUERY) && overlaps && pend_valid_reg;
                step_go   = !scan_done && (!need_emit || out_free);
                if (step_go && need_emit) begin
                    out_load  = 1'b1;
                    out_match = 1'b1;
                    out_last  = 1'b0;
                    out_box   = pend_reg;
                end
            end
            btrq_pkg::ST_FINISH: begin
                out_load = out_free;
                unique case (cmd_reg)
                    btrq_pkg::CMD_REMOVE_ID: begin
                        out_status = any_reg ? btrq_pkg::STATUS_OK : btrq_pkg::STATUS_NONE;
                    end
                    btrq_pkg::CMD_REMOVE_PT: begin
                        out_status = found_reg ? btrq_pkg::STATUS_OK : btrq_pkg::STATUS_NONE;
                        out_match  = found_reg;
                        out_box    = found_reg ? removed_reg : '0;
                    end
                    default: begin
                        out_status = pend_valid_reg ? btrq_pkg::STATUS_OK
                                                    : btrq_pkg::STATUS_NONE;
                        out_match  = pend_valid_reg;
                        out_box    = pend_valid_reg ? pend_reg : '0;
                    end
                endcase
            end
            default: s_ready = 1'b0;
        endcase
    end

    assign push      = step_go && keep;
    assign load_data = (state_reg == btrq_pkg::ST_SCAN) ? head : in_box;
    // A kept head box goes behind the boxes that remain after the shift.
    assign wr_idx    = (state_reg == btrq_pkg::ST_SCAN) ? IDX_W'(occ_reg - 1'b1)
                                                        : IDX_W'(occ_reg);

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        btrq_pkg::box_t nb;
        assign cell_ctrl[i].load  = (push || add_ok) && (wr_idx == IDX_W'(i));
        assign cell_ctrl[i].shift = step_go;
        if (i == MAX_ENTRIES - 1) begin : g_end
            assign nb = cell_q[i];
        end else begin : g_mid
            assign nb = cell_q[i + 1];
        end
        btrq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .load_data (load_data),
            .next_data (nb),
            .q         (cell_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= btrq_pkg::ST_IDLE;
            occ_reg     <= '0;
            steps_reg   <= '0;
            max_r_reg   <= '0;
            max_b_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (add_ok) begin
                occ_reg   <= occ_reg + 1'b1;
                max_r_reg <= add_r;
                max_b_reg <= add_b;
            end
            if (accept) begin
                steps_reg <= occ_reg;
            end
            if (step_go) begin
                steps_reg <= steps_reg - 1'b1;
                if (!keep) begin
                    occ_reg <= occ_reg - 1'b1;
                end
            end
            if ((state_reg == btrq_pkg::ST_SCAN) && scan_done && found_reg
                && (cmd_reg == btrq_pkg::CMD_REMOVE_PT)) begin
                max_r_reg <= cand_r_reg;
                max_b_reg <= cand_b_reg;
            end
        end
    end

    // Command operands and per-scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg        <= s_cmd;
            x_reg          <= s_pos_x;
            y_reg          <= s_pos_y;
            w_reg          <= s_size_w;
            h_reg          <= s_size_h;
            handle_reg     <= s_handle;
            any_reg        <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            cand_r_reg     <= '0;
            cand_b_reg     <= '0;
        end
        if (step_go) begin
            if (id_hit) begin
                any_reg <= 1'b1;
            end
            if (!keep) begin
                found_reg   <= 1'b1;
                removed_reg <= head;
            end else begin
                if (h_right > cand_r_reg) begin
                    cand_r_reg <= h_right;
                end
                if (h_bottom > cand_b_reg) begin
                    cand_b_reg <= h_bottom;
                end
            end
            if ((cmd_reg == btrq_pkg::CMD_QUERY) && overlaps) begin
                pend_valid_reg <= 1'b1;
                pend_reg       <= head;
            end
        end
        if (out_load) begin
            m_status_reg <= out_status;
            m_match_reg  <= out_match;
            m_last_reg   <= out_last;
            m_box_reg    <= out_box;
            m_ext_x_reg  <= out_ext_r[15:0];
            m_ext_y_reg  <= out_ext_b[15:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_match      = m_match_reg;
    assign m_last       = m_last_reg;
    assign m_hit_handle = m_box_reg.id;
    assign m_hit_x      = m_box_reg.left;
    assign m_hit_y      = m_box_reg.top;
    assign m_hit_w      = m_box_reg.width;
    assign m_hit_h      = m_box_reg.height;
    assign m_extent_x   = m_ext_x_reg;
    assign m_extent_y   = m_ext_y_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(MAX_ENTRIES))
        else $error("table occupancy exceeds its depth");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("pending result overwritten");
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == btrq_pkg::ST_SCAN) |-> (steps_reg <= occ_reg))
        else $error("scan step count exceeds occupancy");
    a_idle_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == btrq_pkg::ST_FINISH) && out_free) |=> (state_reg == btrq_pkg::ST_IDLE))
        else $error("controller did not return to idle after final result");
`endif

endmodule

// File: sim/tb_box_table_range_query.sv
// ----------------------------------------------------------------------------
// tb_box_table_range_query: self-checking bench for the box table block
// A directed table covers the empty table, coordinate extremes, zero-size
// boxes and the exclusive edges of remove at point. A random mix of adds,
// removals and queries follows. Results are checked against a behavioral
// table copy or typed directed values, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_box_table_range_query;

    localparam int DEPTH     = 32;
    localparam int N_RANDOM  = 450;
    localparam int MAX_CYC   = 2000000;

    localparam logic [1:0] CMD_ADD       = btrq_pkg::CMD_ADD;
    localparam logic [1:0] CMD_REMOVE_ID = btrq_pkg::CMD_REMOVE_ID;
    localparam logic [1:0] CMD_REMOVE_PT = btrq_pkg::CMD_REMOVE_PT;
    localparam logic [1:0] CMD_QUERY     = btrq_pkg::CMD_QUERY;
    localparam logic [1:0] STATUS_OK     = btrq_pkg::STATUS_OK;
    localparam logic [1:0] STATUS_NONE   = btrq_pkg::STATUS_NONE;
    localparam logic [1:0] STATUS_FULL   = btrq_pkg::STATUS_FULL;

    typedef struct {
        logic [1:0]  status;
        logic        match;
        logic [15:0] hd;
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        last;
    } hit_rec_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic [15:0] hd;
        logic        typed;
        logic [1:0]  st;
        logic [15:0] ex;
        logic [15:0] ey;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = CMD_ADD;
    logic signed [15:0] s_pos_x = '0;
    logic signed [15:0] s_pos_y = '0;
    logic [14:0]        s_size_w = '0;
    logic [14:0]        s_size_h = '0;
    logic [15:0]        s_handle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic               m_match;
    logic [15:0]        m_hit_handle;
    logic signed [15:0] m_hit_x;
    logic signed [15:0] m_hit_y;
    logic [14:0]        m_hit_w;
    logic [14:0]        m_hit_h;
    logic [15:0]        m_extent_x;
    logic [15:0]        m_extent_y;
    logic               m_last;

    box_table_range_query #(.MAX_ENTRIES(DEPTH)) uut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Behavioral copy of the table.
    btrq_pkg::box_t box_tab [DEPTH];
    int       tab_count = 0;
    int       ext_r = 0;
    int       ext_b = 0;
    hit_rec_t pending_hits[$];
    int       err_count = 0;
    int       cyc_count = 0;
    bit       idle_on = 1'b1;
    int       rx_stall = 0;

    function automatic int right_of(btrq_pkg::box_t b);
        return int'($signed(b.left)) + int'(b.width);
    endfunction

    function automatic int bottom_of(btrq_pkg::box_t b);
        return int'($signed(b.top)) + int'(b.height);
    endfunction

    function automatic hit_rec_t make_rec(logic [1:0] st, bit has_box, btrq_pkg::box_t b,
                                          bit lst);
        hit_rec_t r;
        r.status = st;
        r.match  = has_box;
        r.hd     = has_box ? b.id : '0;
        r.x      = has_box ? b.left : '0;
        r.y      = has_box ? b.top : '0;
        r.w      = has_box ? b.width : '0;
        r.h      = has_box ? b.height : '0;
        r.ex     = ext_r[15:0];
        r.ey     = ext_b[15:0];
        r.last   = lst;
        return r;
    endfunction

    // Updates the table for one command and returns its results in order.
    task automatic apply_cmd(input logic [1:0] cmd, input logic [15:0] px, input logic [15:0] py,
                             input logic [14:0] w, input logic [14:0] h,
                             input logic [15:0] hd, output hit_rec_t res[$]);
        int   x, y, k, found;
        btrq_pkg::box_t nb, gone;
        x = int'($signed(px));
        y = int'($signed(py));
        res = {};
        nb = '{id: hd, left: px, top: py, width: w, height: h};
        case (cmd)
            CMD_ADD: begin
                if (tab_count >= DEPTH) begin
                    res.push_back(make_rec(STATUS_FULL, 0, nb, 1));
                end else begin
                    box_tab[tab_count] = nb;
                    tab_count++;
                    if (right_of(nb) > ext_r) ext_r = right_of(nb);
                    if (bottom_of(nb) > ext_b) ext_b = bottom_of(nb);
                    res.push_back(make_rec(STATUS_OK, 0, nb, 1));
                end
            end
            CMD_REMOVE_ID: begin
                k = 0;
                found = 0;
                for (int i = 0; i < tab_count; i++) begin
                    if (box_tab[i].id == hd) found = 1;
                    else begin
                        box_tab[k] = box_tab[i];
                        k++;
                    end
                end
                tab_count = k;
                res.push_back(make_rec(found ? STATUS_OK : STATUS_NONE, 0, nb, 1));
            end
            CMD_REMOVE_PT: begin
                found = -1;
                for (int i = 0; i < tab_count && found < 0; i++) begin
                    if (x >= int'($signed(box_tab[i].left)) && x < right_of(box_tab[i]) &&
                        y >= int'($signed(box_tab[i].top)) && y < bottom_of(box_tab[i]))
                        found = i;
                end
                if (found < 0) begin
                    res.push_back(make_rec(STATUS_NONE, 0, nb, 1));
                end else begin
                    gone = box_tab[found];
                    for (int i = found; i + 1 < tab_count; i++) box_tab[i] = box_tab[i + 1];
                    tab_count--;
                    ext_r = 0;
                    ext_b = 0;
                    for (int i = 0; i < tab_count; i++) begin
                        if (right_of(box_tab[i]) > ext_r) ext_r = right_of(box_tab[i]);
                        if (bottom_of(box_tab[i]) > ext_b) ext_b = bottom_of(box_tab[i]);
                    end
                    res.push_back(make_rec(STATUS_OK, 1, gone, 1));
                end
            end
            default: begin
                for (int i = 0; i < tab_count; i++) begin
                    if (int'($signed(box_tab[i].left)) <= x + int'(w) &&
                        int'($signed(box_tab[i].top)) <= y + int'(h) &&
                        right_of(box_tab[i]) >= x && bottom_of(box_tab[i]) >= y)
                        res.push_back(make_rec(STATUS_OK, 1, box_tab[i], 0));
                end
                if (res.size() == 0) res.push_back(make_rec(STATUS_NONE, 0, nb, 1));
                else res[res.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    // Presents one command, waits for its transfer, then records what it must produce.
    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] px, input logic [15:0] py,
                            input logic [14:0] w, input logic [14:0] h, input logic [15:0] hd,
                            input bit typed, input hit_rec_t typed_rec);
        hit_rec_t res[$];
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_cmd    <= cmd;
        s_pos_x  <= px;
        s_pos_y  <= py;
        s_size_w <= w;
        s_size_h <= h;
        s_handle <= hd;
        s_valid  <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_cmd(cmd, px, py, w, h, hd, res);
        if (typed) pending_hits.push_back(typed_rec);
        else foreach (res[i]) pending_hits.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        hit_rec_t e;
        cyc_count++;
        if (cyc_count > MAX_CYC) begin
            $display("tb_box_table_range_query: FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                e = pending_hits.pop_front();
                check_field("status", e.status, m_status);
                check_field("match", e.match, m_match);
                check_field("hit_handle", e.hd, m_hit_handle);
                check_field("hit_x", e.x, m_hit_x);
                check_field("hit_y", e.y, m_hit_y);
                check_field("hit_w", e.w, m_hit_w);
                check_field("hit_h", e.h, m_hit_h);
                check_field("extent_x", e.ex, m_extent_x);
                check_field("extent_y", e.ey, m_extent_y);
                check_field("last", e.last, m_last);
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            rx_stall = $urandom_range(1, 9) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 6) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 120) - 60);
    endfunction

    function automatic logic [14:0] pick_size();
        if ($urandom_range(0, 6) == 0) return 15'($urandom);
        return 15'($urandom_range(0, 40));
    endfunction

    function automatic logic [15:0] pick_handle();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 7));
    endfunction

    dir_row_t dir_rows[] = '{
        // Empty table: every search misses and the extents are still zero.
        '{CMD_QUERY,     16'h0000, 16'h0000, 15'h7fff, 15'h7fff, 16'h0000, 1, STATUS_NONE, 0, 0},
        '{CMD_REMOVE_ID, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 16'h0005, 1, STATUS_NONE, 0, 0},
        '{CMD_REMOVE_PT, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 16'h0000, 1, STATUS_NONE, 0, 0},
        // Extreme boxes; the negative corner cannot lower the extents.
        '{CMD_ADD,       16'h8000, 16'h8000, 15'h0000, 15'h0000, 16'h0000, 1, STATUS_OK, 0, 0},
        '{CMD_ADD,       16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'hffff, 1, STATUS_OK,
          16'hfffe, 16'hfffe},
        '{CMD_ADD,       16'd10,   16'd20,   15'd5,    15'd5,    16'd7,    1, STATUS_OK,
          16'hfffe, 16'hfffe},
        '{CMD_QUERY,     16'h0000, 16'h0000, 15'h7fff, 15'h7fff, 16'h0000, 0, STATUS_OK, 0, 0},
        // Zero-size box overlaps a zero-size query at the same corner.
        '{CMD_QUERY,     16'h8000, 16'h8000, 15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        '{CMD_QUERY,     16'd15,   16'd25,   15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        '{CMD_REMOVE_PT, 16'd10,   16'd20,   15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        // A zero-size box never contains a point.
        '{CMD_REMOVE_PT, 16'h8000, 16'h8000, 15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        '{CMD_ADD,       16'd10,   16'd20,   15'd5,    15'd5,    16'd9,    0, STATUS_OK, 0, 0},
        '{CMD_ADD,       16'd12,   16'd22,   15'd1,    15'd1,    16'd9,    0, STATUS_OK, 0, 0},
        // Right and bottom edges are outside the box.
        '{CMD_REMOVE_PT, 16'd15,   16'd20,   15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        '{CMD_REMOVE_PT, 16'd10,   16'd25,   15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        '{CMD_REMOVE_PT, 16'd14,   16'd24,   15'h0000, 15'h0000, 16'h0000, 0, STATUS_OK, 0, 0},
        '{CMD_REMOVE_ID, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 16'hffff, 0, STATUS_OK, 0, 0},
        '{CMD_REMOVE_ID, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 16'hffff, 0, STATUS_OK, 0, 0},
        '{CMD_REMOVE_ID, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 16'd9,    0, STATUS_OK, 0, 0},
        '{CMD_QUERY,     16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'h0000, 0, STATUS_OK, 0, 0}
    };

    initial begin
        hit_rec_t tr;
        int       roll, phase;
        logic [1:0] c;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            tr = '{dir_rows[i].st, 1'b0, 16'h0, 16'h0, 16'h0, 15'h0, 15'h0,
                   dir_rows[i].ex, dir_rows[i].ey, 1'b1};
            send_cmd(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
                     dir_rows[i].h, dir_rows[i].hd, dir_rows[i].typed, tr);
        end

        // Phases rotate through add-heavy, mixed and removal-heavy command mixes.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - 70) idle_on = 1'b0;
            phase = (n / 60) % 3;
            roll = $urandom_range(0, 99);
            if (phase == 0) c = roll < 70 ? CMD_ADD : roll < 80 ? CMD_REMOVE_PT : CMD_QUERY;
            else if (phase == 1) c = roll < 30 ? CMD_ADD : roll < 45 ? CMD_REMOVE_ID :
                                     roll < 65 ? CMD_REMOVE_PT : CMD_QUERY;
            else c = roll < 10 ? CMD_ADD : roll < 40 ? CMD_REMOVE_ID :
                     roll < 70 ? CMD_REMOVE_PT : CMD_QUERY;
            send_cmd(c, pick_coord(), pick_coord(), pick_size(), pick_size(), pick_handle(),
                     0, tr);
        end
        s_valid <= 1'b0;

        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_box_table_range_query: PASS");
        end else begin
            $display("tb_box_table_range_query: FAIL");
        end
        $finish;
    end

endmodule

// File: box_table_range_query.f
design/btrq_pkg.sv
design/btrq_cell.sv
design/box_table_range_query.sv
sim/tb_box_table_range_query.sv
